/* rtl/artnet_universe_receiver_sync_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the receiver checker.
// ---------------------------------------------------------------------------
`ifndef ARTNET_UNIVERSE_RECEIVER_SYNC_MACROS_SVH
`define ARTNET_UNIVERSE_RECEIVER_SYNC_MACROS_SVH
// implication checked every clock outside reset
`define AURS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AURS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/aurs_pkg.sv */
// ---------------------------------------------------------------------------
// aurs_pkg
// Types and constants of the Art-Net universe receiver.
// ---------------------------------------------------------------------------
`default_nettype none
package aurs_pkg;
    localparam int MAX_UNIVERSES_DEF = 16;
    localparam int CHANNELS_DEF      = 512;
    localparam logic [15:0] OP_DMX   = 16'h5000;
    localparam logic [15:0] OP_SYNC  = 16'h5200;
    localparam logic [15:0] OP_POLL  = 16'h2000;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam int DATA_MAX = 512;
    localparam logic [10:0] POS_MAX = 11'd2047;

    localparam logic [2:0] F_BYTE = 3'd0;
    localparam logic [2:0] F_TICK = 3'd1;
    localparam logic [2:0] F_FRAME = 3'd2;
    localparam logic [2:0] F_REG  = 3'd3;
    localparam logic [2:0] F_READ = 3'd4;

    localparam logic [3:0] ST_READ   = 4'd0;
    localparam logic [3:0] ST_DMX    = 4'd1;
    localparam logic [3:0] ST_UNK    = 4'd2;
    localparam logic [3:0] ST_SYNC   = 4'd3;
    localparam logic [3:0] ST_POLL   = 4'd4;
    localparam logic [3:0] ST_DROP   = 4'd5;
    localparam logic [3:0] ST_REGD   = 4'd6;
    localparam logic [3:0] ST_DUP    = 4'd7;
    localparam logic [3:0] ST_FULL   = 4'd8;
    localparam logic [3:0] ST_MISS   = 4'd9;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  byte_value;
        logic        last_byte;
        logic [15:0] universe_id;
        logic [9:0]  channel;
    } t_in_item;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] read_data;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture input item
        logic search;     // run table search step
        logic byte_step;  // apply packet byte
        logic tick;
        logic frame;
        logic reg_start;  // begin registration (table write, clear init)
        logic clr_step;   // one bank clear write
        logic copy_rd;    // read staging at counter
        logic copy_wr;    // write bank from staging data
        logic dmx_fin;    // finish dmx commit
        logic sync_set;
        logic rd_issue;   // issue bank read
        logic hdr_clr;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic       search_done;
        logic       found;
        logic       full;
        logic       copy_done;
        logic       short_pkt;
        logic       bad_id;
        logic [15:0] opcode;
        logic       dmx_bad;
        logic       ch_bad;
        logic       ch_zero;
    } t_sts;

    function automatic logic [7:0] id_byte(input logic [2:0] p);
        logic [7:0] r;
        begin
            unique case (p)
                3'd0: r = 8'h41;
                3'd1: r = 8'h72;
                3'd2: r = 8'h74;
                3'd3: r = 8'h2D;
                3'd4: r = 8'h4E;
                3'd5: r = 8'h65;
                3'd6: r = 8'h74;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/aurs_datapath.sv */
// ---------------------------------------------------------------------------
// aurs_datapath
// Header parse, staging, universe table, channel bank memory and sync timer.
// ---------------------------------------------------------------------------
`default_nettype none
module aurs_datapath #(
    parameter int MAX_UNIVERSES = aurs_pkg::MAX_UNIVERSES_DEF,
    parameter int CHANNELS      = aurs_pkg::CHANNELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_wdata,
    input  aurs_pkg::t_in_item     i_item,
    input  aurs_pkg::t_cmd         i_cmd,
    output aurs_pkg::t_sts         o_sts,
    output logic [7:0]             o_rd_data
);
    import aurs_pkg::*;

    localparam int SW = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
    localparam int UW = $clog2(MAX_UNIVERSES + 1);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = SW + 1 + CW;
    localparam int DEPTH = MAX_UNIVERSES * 2 * (1 << CW);

    t_in_item r_item;
    logic [15:0] r_timeout;
    logic [15:0] r_table [MAX_UNIVERSES];
    logic [UW-1:0] r_used;
    logic [MAX_UNIVERSES-1:0] r_active, r_dirty;
    logic [7:0] r_stage [DATA_MAX];
    logic [7:0] r_bank [DEPTH];
    logic [10:0] r_pos;
    logic [11:0] r_n;
    logic r_badid;
    logic [15:0] r_opcode, r_len;
    logic [14:0] r_uni;
    logic r_sync_seen, r_swap_armed;
    logic [15:0] r_sync_age;
    logic [UW-1:0] r_sidx;
    logic [SW-1:0] r_slot;
    logic r_found, r_sdone;
    logic [CW:0] r_cnt;
    logic [CW:0] r_cnt_d;
    logic [7:0] r_sdata;
    logic [7:0] r_rdata;
    logic [15:0] s_key;
    logic [CW:0] s_copy_len;

    assign s_key = (r_item.func == F_BYTE) ? {1'b0, r_uni} : r_item.universe_id;
    assign s_copy_len = (r_len > 16'(CHANNELS)) ? (CW+1)'(CHANNELS) : r_len[CW:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_timeout <= TIMEOUT_RST;
        else if (i_cfg_we) r_timeout <= i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
    end

    // byte parse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_badid <= 1'b0; r_opcode <= '0; r_uni <= '0; r_len <= '0;
            r_n <= '0;
        end else if (i_cmd.hdr_clr) begin
            r_pos <= '0; r_badid <= 1'b0; r_opcode <= '0; r_uni <= '0; r_len <= '0;
        end else if (i_cmd.byte_step) begin
            if (r_pos < 11'd8) begin
                if (r_item.byte_value != id_byte(r_pos[2:0])) r_badid <= 1'b1;
            end else if (r_pos == 11'd8)  r_opcode[7:0] <= r_item.byte_value;
            else if (r_pos == 11'd9)  r_opcode[15:8] <= r_item.byte_value;
            else if (r_pos == 11'd14) r_uni[7:0] <= r_item.byte_value;
            else if (r_pos == 11'd15) r_uni[14:8] <= r_item.byte_value[6:0];
            else if (r_pos == 11'd16) r_len[15:8] <= r_item.byte_value;
            else if (r_pos == 11'd17) r_len[7:0] <= r_item.byte_value;
            r_n <= {1'b0, r_pos} + 12'd1;
            if (r_pos != POS_MAX) r_pos <= r_pos + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_step && r_pos >= 11'd18 && r_pos < 11'd530)
            r_stage[9'(r_pos - 11'd18)] <= r_item.byte_value;
        if (i_cmd.copy_rd) r_sdata <= r_stage[9'(r_cnt)];
    end

    // table search, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidx <= '0; r_found <= 1'b0; r_sdone <= 1'b0; r_slot <= '0;
        end else if (i_cmd.load) begin
            r_sidx <= '0; r_found <= 1'b0; r_sdone <= 1'b0;
        end else if (i_cmd.search && !r_sdone) begin
            if (r_sidx >= r_used || r_sidx >= UW'(MAX_UNIVERSES)) begin
                r_sdone <= 1'b1;
            end else if (r_table[SW'(r_sidx)] == s_key) begin
                r_found <= 1'b1; r_sdone <= 1'b1; r_slot <= SW'(r_sidx);
            end else begin
                r_sidx <= r_sidx + 1'b1;
            end
        end else if (i_cmd.reg_start) begin
            r_slot <= SW'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_start) r_table[SW'(r_used)] <= r_item.universe_id;
    end

    // bank memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)
            r_bank[AW'({r_slot, r_cnt[CW:0]})] <= 8'h00;
        if (i_cmd.copy_wr)
            r_bank[AW'({r_slot, ~r_active[r_slot], r_cnt_d[CW-1:0]})] <= r_sdata;
        if (i_cmd.rd_issue)
            r_rdata <= r_bank[AW'({r_slot, r_active[r_slot], CW'(r_item.channel - 10'd1)})];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_cnt_d <= '0;
        end else begin
            r_cnt_d <= r_cnt;
            if (i_cmd.load) r_cnt <= '0;
            else if (i_cmd.clr_step || i_cmd.copy_rd) r_cnt <= r_cnt + 1'b1;
        end
    end

    // slot state, sync timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_active <= '0; r_dirty <= '0;
            r_sync_seen <= 1'b0; r_sync_age <= '0; r_swap_armed <= 1'b0;
        end else begin
            if (i_cmd.tick && r_sync_age != 16'hFFFF) r_sync_age <= r_sync_age + 16'd1;
            if (i_cmd.frame && r_swap_armed) begin
                r_active <= r_active ^ r_dirty;
                r_dirty <= '0;
                r_swap_armed <= 1'b0;
            end
            if (i_cmd.sync_set) begin
                r_sync_seen <= 1'b1; r_sync_age <= '0; r_swap_armed <= 1'b1;
            end
            if (i_cmd.reg_start) begin
                r_active[SW'(r_used)] <= 1'b0;
                r_dirty[SW'(r_used)] <= 1'b0;
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.dmx_fin) begin
                if (!(r_sync_seen && r_sync_age < r_timeout)) begin
                    r_active[r_slot] <= ~r_active[r_slot];
                    r_dirty[r_slot] <= 1'b0;
                end else begin
                    r_dirty[r_slot] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_sts.search_done = r_sdone;
        o_sts.found       = r_found;
        o_sts.full        = (r_used >= UW'(MAX_UNIVERSES));
        o_sts.copy_done   = (r_cnt >= s_copy_len);
        o_sts.short_pkt   = (r_n < 12'd10);
        o_sts.bad_id      = r_badid;
        o_sts.opcode      = r_opcode;
        o_sts.dmx_bad     = (r_n < 12'd18) || (r_len > 16'd512) ||
                            ({4'd0, r_n} < r_len + 16'd18);
        o_sts.ch_bad      = (r_item.channel > 10'(CHANNELS));
        o_sts.ch_zero     = (r_item.channel == 10'd0);
    end
    assign o_rd_data = r_rdata;
endmodule
`default_nettype wire

/* rtl/aurs_ctrl.sv */
// ---------------------------------------------------------------------------
// aurs_ctrl
// Sequencer for byte, tick, frame, registration and read items.
// ---------------------------------------------------------------------------
`default_nettype none
module aurs_ctrl #(
    parameter int CHANNELS = aurs_pkg::CHANNELS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  aurs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output aurs_pkg::t_out_item o_item,
    output aurs_pkg::t_cmd      o_cmd,
    input  aurs_pkg::t_sts      i_sts,
    input  wire logic [7:0]     i_rd_data
);
    import aurs_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_FIN = 4'd2, S_SRCH = 4'd3,
        S_CLR = 4'd4, S_COPY = 4'd5, S_CEND = 4'd6, S_RD = 4'd7, S_RDW = 4'd8,
        S_OUT = 4'd9, S_CLR2 = 4'd10;

    logic [3:0] r_state, n_state;
    logic r_oval, n_oval;
    t_out_item r_out, n_out;
    t_out_item r_res, n_res;
    logic [CW+1:0] r_ccnt, n_ccnt;
    logic s_fire;

    assign s_fire = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_oval;
    assign o_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_oval <= 1'b0; r_ccnt <= '0;
        end else begin
            r_state <= n_state; r_oval <= n_oval; r_ccnt <= n_ccnt;
        end
        r_out <= n_out;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state; n_oval = r_oval; n_out = r_out; n_res = r_res; n_ccnt = r_ccnt;
        o_cmd = '0;
        if (r_oval && i_ready) n_oval = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                case (i_item.func)
                    F_BYTE: begin
                        o_cmd.byte_step = 1'b1;
                        if (i_item.last_byte) n_state = S_FIN;
                    end
                    F_TICK: o_cmd.tick = 1'b1;
                    F_FRAME: o_cmd.frame = 1'b1;
                    F_REG, F_READ: n_state = S_SRCH;
                    default: n_state = S_IDLE;
                endcase
            end
            S_FIN: begin
                o_cmd.hdr_clr = 1'b1;
                n_state = S_OUT;
                n_res.read_data = 8'h00;
                if (i_sts.short_pkt || i_sts.bad_id) n_res.status = ST_DROP;
                else if (i_sts.opcode == OP_SYNC) begin
                    o_cmd.sync_set = 1'b1; n_res.status = ST_SYNC;
                end else if (i_sts.opcode == OP_POLL) n_res.status = ST_POLL;
                else if (i_sts.opcode != OP_DMX || i_sts.dmx_bad) n_res.status = ST_DROP;
                else begin
                    o_cmd.hdr_clr = 1'b0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_done) begin
                    n_res.read_data = 8'h00;
                    n_state = S_OUT;
                    case (i_item.func)
                        F_BYTE: begin
                            if (!i_sts.found) begin
                                n_res.status = ST_UNK; o_cmd.hdr_clr = 1'b1;
                            end else begin
                                n_state = S_COPY; n_ccnt = '0;
                            end
                        end
                        F_REG: begin
                            if (i_sts.found) n_res.status = ST_DUP;
                            else if (i_sts.full) n_res.status = ST_FULL;
                            else begin
                                o_cmd.reg_start = 1'b1; n_state = S_CLR; n_ccnt = '0;
                            end
                        end
                        default: begin
                            if (!i_sts.found || i_sts.ch_bad) n_res.status = ST_MISS;
                            else if (i_sts.ch_zero) n_res.status = ST_READ;
                            else begin
                                o_cmd.rd_issue = 1'b1; n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                n_ccnt = r_ccnt + 1'b1;
                if (r_ccnt == (CW+2)'(2 * (1 << CW) - 1)) begin
                    n_res.status = ST_REGD; n_state = S_OUT;
                end
            end
            S_COPY: begin
                if (i_sts.copy_done) n_state = S_CEND;
                else begin
                    o_cmd.copy_rd = 1'b1; n_state = S_CLR2;
                end
            end
            S_CLR2: begin
                o_cmd.copy_wr = 1'b1; n_state = S_COPY;
            end
            S_CEND: begin
                o_cmd.dmx_fin = 1'b1; o_cmd.hdr_clr = 1'b1;
                n_res.status = ST_DMX; n_state = S_OUT;
            end
            S_RD: n_state = S_RDW;
            S_RDW: begin
                n_res.status = ST_READ; n_res.read_data = i_rd_data; n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_oval || i_ready) begin
                    n_out = r_res; n_oval = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/artnet_universe_receiver_sync.sv */
// Byte, tick and frame items pass through the dispatch state. A final byte of a valid
// DMX packet adds a table search and a copy of the packet's data bytes into the bank.
// Registration clears 2*CHANNELS (rounded up to a power of two) bank entries, one per
// cycle; a read runs its search, then a registered bank read. One item is processed at
// a time; a waiting result sits in the output register while the next item starts.
// Reset (synchronous, active low) empties the universe table and clears sync state.
// ---------------------------------------------------------------------------
// artnet_universe_receiver_sync
// Art-Net DMX receiver with ArtSync double buffering, top level.
// ---------------------------------------------------------------------------
`default_nettype none
module artnet_universe_receiver_sync #(
    parameter int MAX_UNIVERSES = aurs_pkg::MAX_UNIVERSES_DEF,
    parameter int CHANNELS      = aurs_pkg::CHANNELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  aurs_pkg::t_in_item i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output aurs_pkg::t_out_item o_item
);
    import aurs_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;
    logic [7:0] s_rd;
    t_in_item s_held;
    logic [2:0] r_func;
    logic r_last;

    aurs_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(s_held),
        .o_valid, .i_ready, .o_item, .o_cmd(s_cmd), .i_sts(s_sts), .i_rd_data(s_rd)
    );

    aurs_datapath #(.MAX_UNIVERSES(MAX_UNIVERSES), .CHANNELS(CHANNELS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_item, .i_cmd(s_cmd),
        .o_sts(s_sts), .o_rd_data(s_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func <= i_item.func; r_last <= i_item.last_byte;
        end
    end
    always_comb begin
        s_held = i_item;
        s_held.func = r_func;
        s_held.last_byte = r_last;
    end
endmodule
`default_nettype wire

/* rtl/aurs_checker.sv */
// ---------------------------------------------------------------------------
// aurs_checker
// Port-level checks of the receiver, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "artnet_universe_receiver_sync_macros.svh"
module aurs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic [3:0] o_status,
    input wire logic [7:0] o_data
);
    import aurs_pkg::*;

    `AURS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `AURS_ASSERT_NXT(a_data_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_data))
    `AURS_ASSERT_IMP(a_data_zero, i_clk, i_rst_n, o_valid && o_status != ST_READ, o_data == 8'd0)
    `AURS_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_MISS)
endmodule
bind artnet_universe_receiver_sync aurs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_item.status),
    .o_data(o_item.read_data)
);
`default_nettype wire

/* bench/artnet_universe_receiver_sync_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// artnet_universe_receiver_sync_tb
// Feeds Art-Net packets, ticks, frame starts, registrations and channel reads
// through the item handshake, predicts every status and read value with its own
// copy of the universe table and double buffers, and checks the returned items.
// ---------------------------------------------------------------------------
`default_nettype none
module artnet_universe_receiver_sync_tb;
    import aurs_pkg::*;

    localparam int IW = $bits(t_in_item);

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_item = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_item;

    artnet_universe_receiver_sync dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // packet identifier bytes
    localparam logic [7:0] ART_ID [8] = '{8'h41, 8'h72, 8'h74, 8'h2D,
                                          8'h4E, 8'h65, 8'h74, 8'h00};

    // predicted receiver state
    logic [15:0] sync_timeout = TIMEOUT_RST;
    logic [15:0] uni_ids [16];
    int          uni_count = 0;
    bit          live_bank [16];
    bit          dirty [16];
    logic [7:0]  dmx_banks [16][2][512];
    logic [7:0]  staged [512];
    int          pkt_pos = 0;
    bit          hdr_bad = 0;
    logic [15:0] hdr_op = '0;
    logic [14:0] hdr_uni = '0;
    logic [15:0] hdr_len = '0;
    bit          sync_seen = 0;
    logic [15:0] sync_age = '0;
    bit          swap_armed = 0;

    t_out_item   expected_q [$];
    t_in_item    pending_q [$];
    int          errors = 0;
    int          phase_items = 0;
    logic [15:0] pool [20];

    function automatic int find_uni(input logic [15:0] id);
        for (int i = 0; i < uni_count; i++)
            if (uni_ids[i] == id) return i;
        return -1;
    endfunction

    function automatic logic [3:0] close_packet(input int n);
        int  sl;
        int  cnt;
        bit  pend;
        if (n < 10 || hdr_bad) return ST_DROP;
        if (hdr_op == OP_SYNC) begin
            sync_seen = 1;
            sync_age = '0;
            swap_armed = 1;
            return ST_SYNC;
        end
        if (hdr_op == OP_POLL) return ST_POLL;
        if (hdr_op != OP_DMX) return ST_DROP;
        if (n < 18 || hdr_len > 512 || n < 18 + int'(hdr_len)) return ST_DROP;
        sl = find_uni({1'b0, hdr_uni});
        if (sl < 0) return ST_UNK;
        cnt = hdr_len;
        pend = ~live_bank[sl];
        for (int i = 0; i < cnt; i++) dmx_banks[sl][pend][i] = staged[i];
        if (!(sync_seen && sync_age < sync_timeout)) begin
            live_bank[sl] = pend;
            dirty[sl] = 0;
        end else begin
            dirty[sl] = 1;
        end
        return ST_DMX;
    endfunction

    task automatic predict_item(input t_in_item it);
        t_out_item r;
        bit        has;
        int        sl;
        logic [7:0] b;
        has = 1;
        r = '0;
        b = it.byte_value;
        case (it.func)
            F_BYTE: begin
                if (pkt_pos < 8 && b != ART_ID[pkt_pos]) hdr_bad = 1;
                else if (pkt_pos == 8) hdr_op[7:0] |= b;
                else if (pkt_pos == 9) hdr_op[15:8] |= b;
                else if (pkt_pos == 14) hdr_uni[7:0] |= b;
                else if (pkt_pos == 15) hdr_uni[14:8] |= b[6:0];
                else if (pkt_pos == 16) hdr_len[15:8] |= b;
                else if (pkt_pos == 17) hdr_len[7:0] |= b;
                else if (pkt_pos >= 18 && pkt_pos - 18 < 512) staged[pkt_pos - 18] = b;
                if (!it.last_byte) begin
                    pkt_pos = pkt_pos < 2047 ? pkt_pos + 1 : 2047;
                    has = 0;
                end else begin
                    r.status = close_packet(pkt_pos + 1);
                    pkt_pos = 0;
                    hdr_bad = 0;
                    hdr_op = '0;
                    hdr_uni = '0;
                    hdr_len = '0;
                end
            end
            F_TICK: begin
                if (sync_age != 16'hFFFF) sync_age++;
                has = 0;
            end
            F_FRAME: begin
                if (swap_armed) begin
                    for (int i = 0; i < uni_count; i++)
                        if (dirty[i]) begin
                            live_bank[i] = ~live_bank[i];
                            dirty[i] = 0;
                        end
                    swap_armed = 0;
                end
                has = 0;
            end
            F_REG: begin
                if (find_uni(it.universe_id) >= 0) r.status = ST_DUP;
                else if (uni_count >= 16) r.status = ST_FULL;
                else begin
                    for (int i = 0; i < 512; i++) begin
                        dmx_banks[uni_count][0][i] = '0;
                        dmx_banks[uni_count][1][i] = '0;
                    end
                    uni_ids[uni_count] = it.universe_id;
                    live_bank[uni_count] = 0;
                    dirty[uni_count] = 0;
                    uni_count++;
                    r.status = ST_REGD;
                end
            end
            F_READ: begin
                sl = find_uni(it.universe_id);
                if (sl < 0 || it.channel > 512) r.status = ST_MISS;
                else begin
                    r.status = ST_READ;
                    if (it.channel != 0)
                        r.read_data = dmx_banks[sl][live_bank[sl]][it.channel - 1];
                end
            end
            default: has = 0;
        endcase
        if (has) expected_q.push_back(r);
    endtask

    // sender
    int gap_left = 0;
    bit send_calm = 0;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_item(i_item);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                i_item <= pending_q.pop_front();
                i_valid <= 1'b1;
                gap_left <= draw_gap();
                if ($urandom_range(0, 99) == 0) send_calm <= ~send_calm;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    int hold_left = 0;
    bit press_armed = 0;
    bit press_done = 0;
    bit recv_calm = 0;
    int rdraw;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (press_armed && !press_done) begin
            press_done <= 1'b1;
            hold_left <= 600;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= (hold_left == 1);
        end else begin
            rdraw = $urandom_range(0, 99);
            if (recv_calm || rdraw < 70) i_ready <= 1'b1;
            else if (rdraw < 97) i_ready <= 1'b0;
            else begin
                i_ready <= 1'b0;
                hold_left <= $urandom_range(10, 50);
            end
            if ($urandom_range(0, 199) == 0) recv_calm <= ~recv_calm;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected item, status", o_item.status, -1);
            end else begin
                want = expected_q.pop_front();
                if (o_item.status != want.status)
                    report("status", o_item.status, want.status);
                if (o_item.read_data != want.read_data)
                    report("read_data", o_item.read_data, want.read_data);
            end
        end
    end

    // stimulus helpers
    task automatic queue_item(input logic [2:0] f, input logic [7:0] b, input bit last,
                              input logic [15:0] uid, input logic [9:0] ch);
        t_in_item it;
        it = IW'({$urandom, $urandom});
        it.func = f;
        if (f == F_BYTE) begin
            it.byte_value = b;
            it.last_byte = last;
        end
        if (f == F_REG || f == F_READ) it.universe_id = uid;
        if (f == F_READ) it.channel = ch;
        pending_q.push_back(it);
        phase_items++;
    endtask

    task automatic send_packet(input logic [15:0] op, input logic [14:0] uni,
                               input logic [15:0] len, input int ndata, input int cut,
                               input bit bad_id);
        logic [7:0] bytes [$];
        int n;
        for (int i = 0; i < 8; i++) bytes.push_back(ART_ID[i]);
        if (bad_id) bytes[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        bytes.push_back(op[7:0]);
        bytes.push_back(op[15:8]);
        for (int i = 0; i < 4; i++) bytes.push_back(8'($urandom));
        bytes.push_back(uni[7:0]);
        bytes.push_back({1'($urandom), uni[14:8]});
        bytes.push_back(len[15:8]);
        bytes.push_back(len[7:0]);
        for (int i = 0; i < ndata; i++) bytes.push_back(8'($urandom));
        n = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
        for (int i = 0; i < n; i++) queue_item(F_BYTE, bytes[i], i == n - 1, '0, '0);
    endtask

    function automatic logic [14:0] pick_uni();
        if ($urandom_range(0, 99) < 80) return pool[$urandom_range(0, 15)][14:0];
        return 15'($urandom);
    endfunction

    task automatic random_phase(input int n_items);
        int r;
        int len;
        phase_items = 0;
        while (phase_items < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len = ($urandom_range(0, 19) == 0) ? 512 : $urandom_range(0, 40);
                send_packet(OP_DMX, pick_uni(), 16'(len), len, 0, 0);
            end else if (r < 56) begin
                send_packet(OP_SYNC, 15'($urandom), 16'($urandom), 0,
                            $urandom_range(10, 18), 0);
            end else if (r < 59) begin
                send_packet(OP_POLL, 15'($urandom), 16'($urandom), 0,
                            $urandom_range(10, 18), 0);
            end else if (r < 66) begin
                case ($urandom_range(0, 4))
                    0: send_packet(OP_DMX, pick_uni(), 16'd8, 8, 0, 1);
                    1: send_packet(OP_DMX, pick_uni(), 16'd20, 20, $urandom_range(1, 37), 0);
                    2: send_packet(OP_DMX, pick_uni(), 16'($urandom_range(513, 65535)), 4, 0, 0);
                    3: send_packet(16'($urandom), pick_uni(), 16'd4, 4, 0, 0);
                    default: send_packet(OP_DMX, pick_uni(), 16'd6, 10, 0, 0);
                endcase
            end else if (r < 76) begin
                repeat ($urandom_range(1, 30)) queue_item(F_TICK, '0, 0, '0, '0);
            end else if (r < 83) begin
                queue_item(F_FRAME, '0, 0, '0, '0);
            end else if (r < 95) begin
                queue_item(F_READ, '0, 0,
                           $urandom_range(0, 3) != 0 ? pool[$urandom_range(0, 19)]
                                                      : 16'($urandom),
                           $urandom_range(0, 9) < 7 ? 10'($urandom_range(0, 40))
                                                    : 10'($urandom));
            end else if (r < 98) begin
                queue_item(F_REG, '0, 0, pool[$urandom_range(0, 19)], '0);
            end else begin
                queue_item(3'($urandom_range(5, 7)), '0, 0, '0, '0);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_q.size() > 0 || i_valid || expected_q.size() > 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        sync_timeout = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 20; i++) pool[i] = 16'((i << 11) | $urandom_range(0, 2047));
        pool[0] = 16'h0000;
        pool[15] = 16'h7FFF;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_timeout(16'd1);

        // directed opening
        queue_item(F_READ, '0, 0, pool[0], 10'd1);
        queue_item(F_REG, '0, 0, pool[0], '0);
        queue_item(F_REG, '0, 0, pool[0], '0);
        queue_item(F_REG, '0, 0, pool[15], '0);
        queue_item(F_REG, '0, 0, pool[19], '0);
        queue_item(F_READ, '0, 0, pool[0], 10'd0);
        queue_item(F_READ, '0, 0, pool[15], 10'd512);
        queue_item(F_READ, '0, 0, pool[0], 10'd513);
        queue_item(F_READ, '0, 0, pool[19], 10'd1023);
        queue_item(F_TICK, '0, 0, '0, '0);
        queue_item(F_FRAME, '0, 0, '0, '0);
        queue_item(3'd5, '0, 0, '0, '0);
        queue_item(3'd6, '0, 0, '0, '0);
        queue_item(3'd7, '0, 0, '0, '0);
        queue_item(F_BYTE, 8'hFF, 1, '0, '0);
        send_packet(OP_POLL, '0, '0, 0, 10, 0);
        send_packet(OP_SYNC, '0, '0, 0, 10, 1);
        send_packet(OP_DMX, 15'h7FFF, 16'd3, 3, 0, 0);
        send_packet(OP_DMX, 15'h0000, 16'd2, 2, 0, 0);
        queue_item(F_READ, '0, 0, pool[15], 10'd3);
        send_packet(OP_SYNC, '0, '0, 0, 10, 0);
        send_packet(OP_DMX, 15'h0000, 16'd1, 1, 0, 0);
        queue_item(F_FRAME, '0, 0, '0, '0);
        queue_item(F_READ, '0, 0, pool[0], 10'd1);
        press_armed = 1;
        random_phase(400);
        wait_idle();

        write_timeout(16'd65535);
        send_packet(OP_DMX, pool[0][14:0], 16'd512, 512, 0, 0);
        random_phase(200);
        wait_idle();

        write_timeout(16'd20);
        random_phase(100);
        send_packet(OP_SYNC, '0, '0, 0, 10, 0);
        send_packet(OP_DMX, pool[1][14:0], 16'd4, 4, 0, 0);
        repeat (25) queue_item(F_TICK, '0, 0, '0, '0);
        random_phase(100);
        wait_idle();

        write_timeout(16'($urandom_range(2, 200)));
        random_phase(300);
        wait_idle();

        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
